// ===== rtl/cfp_pkg.sv =====
`default_nettype none

package cfp_pkg;

    localparam int PACKET_MAX_LEN = 8;
    localparam int HEAD_DEPTH     = 5;
    localparam int IDX_W          = $clog2(PACKET_MAX_LEN);
    localparam int TIME_W         = 64;
    localparam int VAL_W          = 7;

    localparam logic [7:0] CH_TERM    = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_MOVE    = 8'h4d;
    localparam logic [7:0] CH_PARK    = 8'h50;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_MAX_LEN - 1);

    typedef enum logic
    {
        CMD_MOVE = 1'b0,
        CMD_PARK = 1'b1
    } command_t;

    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

    typedef struct packed
    {
        logic             hit;
        command_t         command;
        logic [VAL_W-1:0] move_x;
        logic [VAL_W-1:0] move_y;
    } decode_t;

    typedef struct packed
    {
        logic              valid;
        command_t          command;
        logic [VAL_W-1:0]  move_x;
        logic [VAL_W-1:0]  move_y;
        logic [TIME_W-1:0] start_time_us;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/cfp_decode.sv =====
`default_nettype none

module cfp_decode
(
    input  wire  cfp_pkg::head_t   head,
    output cfp_pkg::decode_t       dec
);
    import cfp_pkg::*;

    logic [3:0] digit [1:4];
    logic       all_digits;

    always_comb
    begin
        all_digits = 1'b1;
        for (int i = 1; i < HEAD_DEPTH; i++)
        begin
            digit[i] = 4'(head[i] - CH_ZERO);
            if (head[i] < CH_ZERO || head[i] > CH_NINE)
            begin
                all_digits = 1'b0;
            end
        end
    end

    always_comb
    begin
        dec.hit     = 1'b0;
        dec.command = CMD_PARK;
        dec.move_x  = '0;
        dec.move_y  = '0;
        if (head[0] == CH_MOVE)
        begin
            dec.hit     = all_digits;
            dec.command = CMD_MOVE;
            // tens * 10 as shift-and-add
            dec.move_x  = VAL_W'({digit[1], 3'b000}) + VAL_W'({digit[1], 1'b0})
                        + VAL_W'(digit[2]);
            dec.move_y  = VAL_W'({digit[3], 3'b000}) + VAL_W'({digit[3], 1'b0})
                        + VAL_W'(digit[4]);
        end
        else if (head[0] == CH_PARK)
        begin
            dec.hit     = 1'b1;
            dec.command = CMD_PARK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfp_frame.sv =====
`default_nettype none

module cfp_frame
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        step,
    input  wire  [7:0]                 rx_byte,
    input  wire  [cfp_pkg::TIME_W-1:0] rx_time_us,
    output cfp_pkg::result_t           result
);
    import cfp_pkg::*;

    head_t             head_reg;
    head_t             head_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              after_term_reg;
    logic              after_term_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic              is_term;
    logic              take;
    decode_t           dec;

    assign is_term = (rx_byte == CH_TERM);
    assign take    = step && (rx_byte != CH_NEWLINE);

    always_comb
    begin
        head_next       = head_reg;
        idx_next        = idx_reg;
        after_term_next = after_term_reg;
        start_next      = start_reg;
        if (take)
        begin
            if (after_term_reg)
            begin
                start_next = rx_time_us;
            end
            for (int i = 0; i < HEAD_DEPTH; i++)
            begin
                if ({{(32-IDX_W){1'b0}}, idx_reg} == 32'(i))
                begin
                    head_next[i] = rx_byte;
                end
            end
            if (is_term || idx_reg == IDX_LAST)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
            after_term_next = is_term;
        end
    end

    // decode sees the head with the terminator already stored
    cfp_decode u_decode
    (
        .head (head_next),
        .dec  (dec)
    );

    always_comb
    begin
        result.valid         = take && is_term && dec.hit;
        result.command       = dec.command;
        result.move_x        = dec.move_x;
        result.move_y        = dec.move_y;
        result.start_time_us = start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            after_term_reg <= 1'b1;
            start_reg      <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            after_term_reg <= after_term_next;
            start_reg      <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

endmodule

`default_nettype wire

// ===== rtl/command_frame_parser.sv =====
`default_nettype none

// command frame parser: turns received serial bytes into move and park commands
// input stream: one item per byte with its microsecond arrival time;
//   newline bytes are dropped, a zero byte ends a packet
// output stream: one item per decoded packet, none for a dropped packet;
//   tuser carries the command kind (0 move, 1 park), tdata the two values
//   and the arrival time of the packet's first byte
// an accepted item waits in the input register and is parsed out of it once the
//   output register can take its outcome; its result, if any, is registered there
// throughput: one item per cycle while the output is not stalled; the input register and the output register
//   advance together, so a full output register that is not taken holds the
//   input register, and s_axis_tready falls only while both are full
// reset clears both valid flags, the packet position and the start time, and
//   arms the start time to latch on the next stored byte; the stored head bytes
//   are not cleared and a packet is always written before it is decoded
// a receiver stall never drops or repeats a result: the state advances only
//   when the output register can take the outcome of the byte

module command_frame_parser
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,  // rx_byte[7:0], rx_time_us[71:8]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,  // move_x[6:0], move_y[13:7], start_time_us[77:14], zero
    output logic [0:0]  m_axis_tuser   // command[0]
);
    import cfp_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_ready;
    logic              advance;
    result_t           result;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= advance && result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_time_reg <= s_axis_tdata[71:8];
        end
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    cfp_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .rx_time_us (in_time_reg),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.command;
    assign m_axis_tdata  = {2'b00, out_reg.start_time_us, out_reg.move_y, out_reg.move_x};

endmodule

`default_nettype wire

// ===== bench/command_frame_parser_tb.sv =====
`default_nettype none

module command_frame_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    typedef struct packed
    {
        command_t          kind;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [TIME_W-1:0] start_us;
    } frame_cmd_t;

    typedef struct packed
    {
        logic [7:0]        rx;
        logic [TIME_W-1:0] t_us;
        bit                known;
        bit                known_hit;
        frame_cmd_t        known_cmd;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // rx_byte[7:0], rx_time_us[71:8]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // move_x[6:0], move_y[13:7], start_time_us[77:14], zero
    logic [0:0]  m_axis_tuser;   // command[0]

    // parser state as seen from the byte stream
    logic [7:0]        head_seen [HEAD_DEPTH];
    int                pkt_pos     = 0;
    bit                after_zero  = 1'b1;
    logic [TIME_W-1:0] pkt_start   = '0;

    frame_cmd_t  pending_cmds [$];
    step_row_t   dir_rows [$];
    logic [63:0] now_us = 64'd1000;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    int mismatches   = 0;
    int bytes_sent   = 0;
    int moves_seen   = 0;
    int parks_seen   = 0;

    command_frame_parser u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic bit is_dec_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int two_dec(logic [7:0] hi, logic [7:0] lo);
        return (int'(hi) - int'(CH_ZERO)) * 10 + (int'(lo) - int'(CH_ZERO));
    endfunction

    // advances the parser state by one byte; returns 1 when a command comes out
    function automatic bit parse_byte(logic [7:0] rx, logic [TIME_W-1:0] t_us,
                                      output frame_cmd_t cmd);
        bit hit;
        hit = 1'b0;
        cmd = '0;
        if (rx == CH_NEWLINE)
            return 1'b0;
        if (after_zero)
            pkt_start = t_us;
        if (pkt_pos < HEAD_DEPTH)
            head_seen[pkt_pos] = rx;
        pkt_pos++;
        if (rx == CH_TERM)
        begin
            if (head_seen[0] == CH_MOVE)
            begin
                if (is_dec_digit(head_seen[1]) && is_dec_digit(head_seen[2]) &&
                    is_dec_digit(head_seen[3]) && is_dec_digit(head_seen[4]))
                begin
                    cmd.kind     = CMD_MOVE;
                    cmd.x        = VAL_W'(two_dec(head_seen[1], head_seen[2]));
                    cmd.y        = VAL_W'(two_dec(head_seen[3], head_seen[4]));
                    cmd.start_us = pkt_start;
                    hit          = 1'b1;
                end
            end
            else if (head_seen[0] == CH_PARK)
            begin
                cmd.kind     = CMD_PARK;
                cmd.start_us = pkt_start;
                hit          = 1'b1;
            end
            pkt_pos = 0;
        end
        else if (pkt_pos >= PACKET_MAX_LEN)
        begin
            // overflow: wrap without re-latching the start time
            pkt_pos = 0;
        end
        after_zero = (rx == CH_TERM);
        return hit;
    endfunction

    function automatic void row_plain(logic [7:0] rx, logic [63:0] t_us);
        step_row_t r;
        r      = '0;
        r.rx   = rx;
        r.t_us = t_us;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_known(logic [7:0] rx, logic [63:0] t_us, bit hit,
                                      command_t kind, int x, int y, logic [63:0] s_us);
        step_row_t r;
        r                    = '0;
        r.rx                 = rx;
        r.t_us               = t_us;
        r.known              = 1'b1;
        r.known_hit          = hit;
        r.known_cmd.kind     = kind;
        r.known_cmd.x        = VAL_W'(x);
        r.known_cmd.y        = VAL_W'(y);
        r.known_cmd.start_us = s_us;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [63:0] next_time();
        if ($urandom_range(15) == 0)
            return {$urandom, $urandom};
        now_us += 64'($urandom_range(1, 2000));
        return now_us;
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == CH_NEWLINE)
            b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [7:0] dec_char();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // one item on the input side; known rows replace the predicted outcome
    task automatic send_byte(input logic [7:0] rx, input logic [63:0] t_us,
                             input bit known, input bit known_hit,
                             input frame_cmd_t known_cmd);
        frame_cmd_t cmd;
        bit         hit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t_us, rx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit = parse_byte(rx, t_us, cmd);
        if (known)
        begin
            hit = known_hit;
            cmd = known_cmd;
        end
        if (hit)
            pending_cmds.push_back(cmd);
        if (rx != CH_NEWLINE)
            bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_packet();
        logic [7:0] pkt [$];
        int         kind;
        int         k;
        kind = $urandom_range(99);
        if (kind < 40)
        begin
            // well-formed move, now and then with a newline inside
            pkt.push_back(CH_MOVE);
            repeat (4) pkt.push_back(dec_char());
            if ($urandom_range(9) == 0)
                pkt.insert($urandom_range(1, 4), CH_NEWLINE);
            pkt.push_back(CH_TERM);
        end
        else if (kind < 60)
        begin
            pkt.push_back(CH_PARK);
            repeat ($urandom_range(6)) pkt.push_back(body_byte());
            pkt.push_back(CH_TERM);
        end
        else if (kind < 75)
        begin
            // move with one non-digit among the four value chars
            pkt.push_back(CH_MOVE);
            repeat (4) pkt.push_back(dec_char());
            k = $urandom_range(1, 4);
            case ($urandom_range(2))
                0:       pkt[k] = CH_ZERO - 8'd1;
                1:       pkt[k] = CH_NINE + 8'd1;
                default:
                begin
                    do
                        pkt[k] = body_byte();
                    while (is_dec_digit(pkt[k]));
                end
            endcase
            repeat ($urandom_range(2)) pkt.push_back(body_byte());
            pkt.push_back(CH_TERM);
        end
        else if (kind < 85)
        begin
            // short or empty packet
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(2))
                    0:       pkt.push_back(CH_MOVE);
                    1:       pkt.push_back(CH_PARK);
                    default: pkt.push_back(body_byte());
                endcase
                repeat ($urandom_range(3)) pkt.push_back(dec_char());
            end
            pkt.push_back(CH_TERM);
        end
        else if (kind < 93)
        begin
            repeat ($urandom_range(8, 14)) pkt.push_back(body_byte());
            if ($urandom_range(1) == 0)
                pkt.push_back(CH_TERM);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(255)));
        end
        foreach (pkt[i])
            send_byte(pkt[i], next_time(), 1'b0, 1'b0, '0);
    endtask

    task automatic drain_results();
        while (pending_cmds.size() != 0)
            @(negedge clk);
    endtask

    // receiver side: random stalls plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = 64;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                report_mismatch($sformatf("unexpected command, tuser=%0d tdata=%h",
                                          m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (command_t'(m_axis_tuser[0]) != want.kind)
                    report_mismatch($sformatf("command got %0d want %0d",
                                              m_axis_tuser[0], want.kind));
                if (m_axis_tdata[6:0] != want.x)
                    report_mismatch($sformatf("move_x got %0d want %0d",
                                              m_axis_tdata[6:0], want.x));
                if (m_axis_tdata[13:7] != want.y)
                    report_mismatch($sformatf("move_y got %0d want %0d",
                                              m_axis_tdata[13:7], want.y));
                if (m_axis_tdata[77:14] != want.start_us)
                    report_mismatch($sformatf("start_time_us got %h want %h",
                                              m_axis_tdata[77:14], want.start_us));
                if (want.kind == CMD_MOVE)
                    moves_seen++;
                else
                    parks_seen++;
            end
        end
    end

    initial
    begin
        #2ms;
        $display("timeout: %0d commands still outstanding", pending_cmds.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        step_row_t r;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // park, empty packet, extreme time, newline inside a packet
        row_plain(CH_PARK, 64'd100);
        row_known(CH_TERM, 64'd101, 1'b1, CMD_PARK, 0, 0, 64'd100);
        row_known(CH_TERM, 64'd102, 1'b0, CMD_PARK, 0, 0, 64'd0);
        row_plain(CH_MOVE, 64'hFFFF_FFFF_FFFF_FFFF);
        row_plain(CH_NINE, 64'd1);
        row_plain(CH_NINE, 64'd2);
        row_plain(CH_NEWLINE, 64'd0);
        row_plain(CH_ZERO, 64'd3);
        row_plain(CH_ZERO, 64'd4);
        row_known(CH_TERM, 64'd5, 1'b1, CMD_MOVE, 99, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        // terminator in the last slot, extra bytes past the head
        row_plain(CH_MOVE, 64'd7);
        row_plain(CH_ZERO, 64'd8);
        row_plain(CH_ZERO, 64'd9);
        row_plain(CH_NINE, 64'd10);
        row_plain(CH_NINE, 64'd11);
        row_plain(8'h41, 64'd12);
        row_plain(8'hFF, 64'd13);
        row_known(CH_TERM, 64'd14, 1'b1, CMD_MOVE, 0, 99, 64'd7);
        // eight bytes without terminator wrap; start time stays latched
        row_plain(CH_MOVE, 64'd200);
        for (int d = 1; d <= 7; d++)
            row_plain(CH_ZERO + 8'(d), 64'(200 + d));
        row_plain(CH_PARK, 64'd300);
        row_known(CH_TERM, 64'd301, 1'b1, CMD_PARK, 0, 0, 64'd200);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 81;
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            send_byte(r.rx, r.t_us, r.known, r.known_hit, r.known_cmd);
        end
        while (bytes_sent < 240)
            send_random_packet();

        s_axis_tvalid <= 1'b0;
        drain_results();
        send_idle_pct = 81;
        recv_idle_pct = 27;
        while (bytes_sent < 450)
            send_random_packet();

        // back-to-back parks against a stalled receiver
        s_axis_tvalid <= 1'b0;
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        repeat (12)
        begin
            send_byte(CH_PARK, next_time(), 1'b0, 1'b0, '0);
            send_byte(CH_TERM, next_time(), 1'b0, 1'b0, '0);
        end
        while (bytes_sent < 650)
            send_random_packet();

        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (16) @(negedge clk);

        $display("sent %0d bytes; checked %0d move and %0d park commands", bytes_sent,
                 moves_seen, parks_seen);
        $display("covered overflow, malformed and short packets, stalls and a long hold");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cfp_pkg.sv
rtl/cfp_decode.sv
rtl/cfp_frame.sv
rtl/command_frame_parser.sv
bench/command_frame_parser_tb.sv
